/* design/dry_aware_triangle_interpolator_assert.svh */
// Assertion macros shared by the interpolator RTL.
// No dependencies; taken in by `include where checks are written.
`ifndef DRY_AWARE_TRIANGLE_INTERPOLATOR_ASSERT_SVH
`define DRY_AWARE_TRIANGLE_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DATI_ASSERT_IMP(LBL, CLK, RSTN, ANTE, CONS) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
        else $error("dati: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DATI_ASSERT_NEXT(LBL, CLK, RSTN, ANTE, CONS) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
        else $error("dati: next-cycle check failed");

`endif

/* design/dati_pkg.sv */
// Shared constants, types and the arctangent table for the interpolator.
// No dependencies; used by all modules through scoped names.
package dati_pkg;

    localparam int VALUE_FRAC_BITS_DEF = 10;
    localparam int CORDIC_STEPS_DEF    = 16;
    localparam int CORDIC_MAX          = 24;

    localparam int VAL_W     = 32;
    localparam int W_W       = 16;
    localparam int FLOW_W    = 17;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 1;

    // Output modes
    localparam logic [MODE_W-1:0] MODE_SCALAR    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_VECTOR    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MAGNITUDE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_DIRECTION = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_MODE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_VALUE = 1'b1;

    localparam logic signed [VAL_W-1:0] DEFAULT_RESET = -32'sd102398976;
    localparam logic signed [VAL_W-1:0] VAL_MAX       = 32'sh7FFF_FFFF;

    // Angles in degrees with 16 fraction bits
    localparam int ANG_W    = 32;
    localparam int ANG_FRAC = 16;
    localparam logic signed [ANG_W-1:0] ANG_180  = 32'sd11796480;
    localparam logic signed [ANG_W-1:0] ANG_M180 = -32'sd11796480;
    localparam logic signed [ANG_W-1:0] ANG_360  = 32'sd23592960;
    localparam logic signed [ANG_W-1:0] ANG_90   = 32'sd5898240;
    localparam logic signed [ANG_W-1:0] ANG_M90  = -32'sd5898240;

    localparam int CORDIC_W = 36;

    // Integer square root: 64-bit radicand, one result bit per stage
    localparam int SQRT_IN_W   = 64;
    localparam int SQRT_OUT_W  = 32;
    localparam int SQRT_STAGES = 32;
    localparam int SQRT_REM_W  = SQRT_OUT_W + 2;

    // Interpolation lane
    localparam int PROD_W     = VAL_W + W_W + 1;
    localparam int NUM_W      = PROD_W + 2;
    localparam int DIV_W      = 50;
    localparam int DEN_W      = 18;
    localparam int WEIGHT_ONE = 32768;
    localparam int LANE_LAT   = 3 + DIV_W + 1;

    // Lane result kinds
    localparam logic [1:0] KIND_DFLT  = 2'd0;
    localparam logic [1:0] KIND_FIRST = 2'd1;
    localparam logic [1:0] KIND_DIV   = 2'd2;

    typedef struct packed {
        logic [1:0]              kind;
        logic                    neg;
        logic [DEN_W-1:0]        den;
        logic signed [VAL_W-1:0] first;
    } lane_side_t;

    typedef struct packed {
        logic                     found;
        logic                     hasf;
        logic signed [FLOW_W-1:0] flow;
    } item_flags_t;

    // atan(2^-i) in degrees, 16 fraction bits
    function automatic logic signed [ANG_W-1:0] atan_entry(input int idx);
        case (idx)
            0:       return 32'sd2949120;
            1:       return 32'sd1740967;
            2:       return 32'sd919879;
            3:       return 32'sd466945;
            4:       return 32'sd234379;
            5:       return 32'sd117305;
            6:       return 32'sd58665;
            7:       return 32'sd29335;
            8:       return 32'sd14668;
            9:       return 32'sd7334;
            10:      return 32'sd3667;
            11:      return 32'sd1833;
            12:      return 32'sd917;
            13:      return 32'sd458;
            14:      return 32'sd229;
            15:      return 32'sd115;
            16:      return 32'sd57;
            17:      return 32'sd29;
            18:      return 32'sd14;
            19:      return 32'sd7;
            20:      return 32'sd4;
            21:      return 32'sd2;
            22:      return 32'sd1;
            default: return 32'sd0;
        endcase
    endfunction

endpackage

/* design/dry_aware_triangle_interpolator.sv */
// Dry-aware barycentric triangle interpolator, top level.
// Channels: item beat (valid/ready) carries one triangle's corners, weights and flags;
// result beat (valid/ready) carries first_result and second_result. Config is a
// plain write port (cfg_write_en, cfg_index, cfg_data): index 0 output mode,
// index 1 default (dry) value; write only while the block is idle.
// Item beat to result beat: corner magnitude square root, interpolation lanes,
// vector magnitude and CORDIC, final select; the depth is the same for any
// parameter values. Throughput: one beat per cycle when not stalled.
// The whole pipeline advances together; it stalls only while a result sits in
// the output register and result_ready is low, and then item_ready drops too.
// Reset clears all valid bits and sets mode to scalar and the default value to
// its reset marker; payload registers are not reset.
// Depends on dati_pkg, dati_sqrt, dati_lane, dati_cordic and the assertion header.
module dry_aware_triangle_interpolator #(
    parameter int VALUE_FRAC_BITS = dati_pkg::VALUE_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS    = dati_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write_en,
    input  logic [dati_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [dati_pkg::VAL_W-1:0]            cfg_data,
    input  logic                                  item_valid,
    output logic                                  item_ready,
    input  logic                                  station_found,
    input  logic                                  has_flow_direction,
    input  logic signed [dati_pkg::FLOW_W-1:0]    flow_direction,
    input  logic signed [dati_pkg::VAL_W-1:0]     u_node_a,
    input  logic signed [dati_pkg::VAL_W-1:0]     u_node_b,
    input  logic signed [dati_pkg::VAL_W-1:0]     u_node_c,
    input  logic signed [dati_pkg::VAL_W-1:0]     v_node_a,
    input  logic signed [dati_pkg::VAL_W-1:0]     v_node_b,
    input  logic signed [dati_pkg::VAL_W-1:0]     v_node_c,
    input  logic [dati_pkg::W_W-1:0]              weight_a,
    input  logic [dati_pkg::W_W-1:0]              weight_b,
    input  logic [dati_pkg::W_W-1:0]              weight_c,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output logic signed [dati_pkg::VAL_W-1:0]     first_result,
    output logic signed [dati_pkg::VAL_W-1:0]     second_result
);

`include "dry_aware_triangle_interpolator_assert.svh"

    localparam int VW         = dati_pkg::VAL_W;
    localparam int PRE_LAT    = 2 + dati_pkg::SQRT_STAGES;
    localparam int POST_LAT   = 2 + dati_pkg::SQRT_STAGES;
    localparam int SIDE_LAT   = PRE_LAT + dati_pkg::LANE_LAT + POST_LAT;
    localparam int LAT        = SIDE_LAT + 2;
    localparam int CORDIC_LAT = 1 + CORDIC_STEPS;
    localparam int ANG_DLY    = POST_LAT - CORDIC_LAT;
    localparam int ANG_SH     = dati_pkg::ANG_FRAC - VALUE_FRAC_BITS;
    localparam int DIR_W      = VW + 2;

    typedef struct packed {
        logic [2:0][VW-1:0]             u;
        logic [2:0][VW-1:0]             v;
        logic [2:0][dati_pkg::W_W-1:0]  w;
    } corners_t;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
    } vec_t;

    typedef struct packed {
        logic                 found;
        logic                 hasf;
        logic                 uvd;
        logic signed [VW-1:0] vx;
        logic signed [VW-1:0] vy;
        logic signed [VW-1:0] ang;
        logic signed [VW-1:0] smag;
    } fin_t;

    // configuration registers
    logic [dati_pkg::MODE_W-1:0] mode_reg;
    logic signed [VW-1:0]        dflt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= dati_pkg::MODE_SCALAR;
            dflt_reg <= dati_pkg::DEFAULT_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                dati_pkg::CFG_OUTPUT_MODE:   mode_reg <= cfg_data[dati_pkg::MODE_W-1:0];
                dati_pkg::CFG_DEFAULT_VALUE: dflt_reg <= $signed(cfg_data);
                default:                     mode_reg <= mode_reg;
            endcase
        end
    end

    // pipeline advance and valid chain
    logic           en;
    logic [LAT-1:0] vld_reg;

    assign en         = !vld_reg[LAT-1] || result_ready;
    assign item_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], item_valid};
        end
    end

    // item side data
    corners_t              cin;
    dati_pkg::item_flags_t fin_in;
    corners_t              uvw_reg [PRE_LAT];
    dati_pkg::item_flags_t flg_reg [SIDE_LAT];

    assign cin.u = {u_node_c, u_node_b, u_node_a};
    assign cin.v = {v_node_c, v_node_b, v_node_a};
    assign cin.w = {weight_c, weight_b, weight_a};
    assign fin_in.found = station_found;
    assign fin_in.hasf  = has_flow_direction;
    assign fin_in.flow  = flow_direction;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            uvw_reg[0] <= cin;
            for (int k = 1; k < PRE_LAT; k++)
            begin
                uvw_reg[k] <= uvw_reg[k-1];
            end
            flg_reg[0] <= fin_in;
            for (int k = 1; k < SIDE_LAT; k++)
            begin
                flg_reg[k] <= flg_reg[k-1];
            end
        end
    end

    // corner magnitudes: square, sum, square root
    logic signed [2*VW-1:0] usq_reg [3];
    logic signed [2*VW-1:0] vsq_reg [3];
    logic [2*VW-1:0]        csum_reg [3];
    logic [VW-1:0]          croot [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                usq_reg[i]  <= $signed(cin.u[i]) * $signed(cin.u[i]);
                vsq_reg[i]  <= $signed(cin.v[i]) * $signed(cin.v[i]);
                csum_reg[i] <= $unsigned(usq_reg[i]) + $unsigned(vsq_reg[i]);
            end
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_corner
        dati_sqrt u_sqrt (
            .clk      (clk),
            .en       (en),
            .radicand (csum_reg[i]),
            .root     (croot[i])
        );
    end

    // lane inputs: x lane takes magnitudes in magnitude mode without flow direction, else u
    corners_t              cpre;
    dati_pkg::item_flags_t fpre;
    logic                  mag_mode;
    logic [2:0][VW-1:0]    x_val;
    logic [2:0]            x_wet, y_wet;
    logic signed [VW-1:0]  res_x, res_y;

    always_comb
    begin
        cpre     = uvw_reg[PRE_LAT-1];
        fpre     = flg_reg[PRE_LAT-1];
        mag_mode = (mode_reg == dati_pkg::MODE_MAGNITUDE) && !fpre.hasf;
        for (int i = 0; i < 3; i++)
        begin
            y_wet[i] = (cpre.v[i] != dflt_reg);
            if (mag_mode)
            begin
                x_val[i] = croot[i][VW-1] ? dati_pkg::VAL_MAX : croot[i];
                x_wet[i] = (cpre.u[i] != dflt_reg) && y_wet[i];
            end
            else
            begin
                x_val[i] = cpre.u[i];
                x_wet[i] = (cpre.u[i] != dflt_reg);
            end
        end
    end

    dati_lane u_lane_x (
        .clk    (clk),
        .en     (en),
        .dflt   (dflt_reg),
        .val    (x_val),
        .wet    (x_wet),
        .wgt    (cpre.w),
        .result (res_x)
    );

    dati_lane u_lane_y (
        .clk    (clk),
        .en     (en),
        .dflt   (dflt_reg),
        .val    (cpre.v),
        .wet    (y_wet),
        .wgt    (cpre.w),
        .result (res_y)
    );

    // interpolated vector: magnitude and direction
    logic signed [2*VW-1:0] pxsq_reg, pysq_reg;
    logic [2*VW-1:0]        psum_reg;
    logic [VW-1:0]          proot;
    logic signed [VW-1:0]   ang_raw;
    vec_t                   vxy_reg [POST_LAT];
    logic signed [VW-1:0]   ang_reg [ANG_DLY];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pxsq_reg   <= res_x * res_x;
            pysq_reg   <= res_y * res_y;
            psum_reg   <= $unsigned(pxsq_reg) + $unsigned(pysq_reg);
            vxy_reg[0] <= {res_x, res_y};
            for (int k = 1; k < POST_LAT; k++)
            begin
                vxy_reg[k] <= vxy_reg[k-1];
            end
            ang_reg[0] <= ang_raw;
            for (int k = 1; k < ANG_DLY; k++)
            begin
                ang_reg[k] <= ang_reg[k-1];
            end
        end
    end

    dati_sqrt u_vec_sqrt (
        .clk      (clk),
        .en       (en),
        .radicand (psum_reg),
        .root     (proot)
    );

    dati_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .en    (en),
        .x     (res_x),
        .y     (res_y),
        .angle (ang_raw)
    );

    // angle rounding to the output format
    logic signed [VW-1:0] ang_a, ang_out;
    assign ang_a = ang_reg[ANG_DLY-1];

    if (ANG_SH > 0) begin : g_ang_down
        logic [VW:0] am, aq;
        always_comb
        begin
            am      = ang_a[VW-1] ? ((VW+1)'(0) - {ang_a[VW-1], ang_a}) : {1'b0, ang_a};
            aq      = (am + ((VW+1)'(1) << (ANG_SH - 1))) >> ANG_SH;
            ang_out = ang_a[VW-1] ? $signed(VW'((VW+1)'(0) - aq)) : $signed(aq[VW-1:0]);
        end
    end
    else if (ANG_SH == 0) begin : g_ang_same
        assign ang_out = ang_a;
    end
    else begin : g_ang_up
        assign ang_out = ang_a <<< (-ANG_SH);
    end

    // final stage 1: signed magnitude against flow direction
    localparam logic signed [DIR_W-1:0] D180  = DIR_W'(dati_pkg::ANG_180);
    localparam logic signed [DIR_W-1:0] DM180 = DIR_W'(dati_pkg::ANG_M180);
    localparam logic signed [DIR_W-1:0] D360  = DIR_W'(dati_pkg::ANG_360);
    localparam logic signed [DIR_W-1:0] D90   = DIR_W'(dati_pkg::ANG_90);
    localparam logic signed [DIR_W-1:0] DM90  = DIR_W'(dati_pkg::ANG_M90);

    dati_pkg::item_flags_t fpost;
    vec_t                  vpost;
    logic signed [VW-1:0]  mag;
    logic signed [DIR_W-1:0] dir0, dir1, flow_sh;
    fin_t                  f1_next, f1_reg;

    always_comb
    begin
        fpost   = flg_reg[SIDE_LAT-1];
        vpost   = vxy_reg[POST_LAT-1];
        mag     = proot[VW-1] ? dati_pkg::VAL_MAX : $signed(proot);
        flow_sh = $signed({{(DIR_W-dati_pkg::FLOW_W-9){fpost.flow[dati_pkg::FLOW_W-1]}},
                           fpost.flow, 9'b0});
        dir0    = $signed({{2{ang_a[VW-1]}}, ang_a}) - flow_sh;
        if (dir0 < DM180)
        begin
            dir1 = dir0 + D360;
        end
        else if (dir0 > D180)
        begin
            dir1 = dir0 - D360;
        end
        else
        begin
            dir1 = dir0;
        end
        f1_next.found = fpost.found;
        f1_next.hasf  = fpost.hasf;
        f1_next.uvd   = (vpost.x == dflt_reg) || (vpost.y == dflt_reg);
        f1_next.vx    = vpost.x;
        f1_next.vy    = vpost.y;
        f1_next.ang   = ang_out;
        f1_next.smag  = ((dir1 < D90) && (dir1 > DM90)) ? mag : -mag;
    end

    // final stage 2: select by mode into the output register
    logic signed [VW-1:0] r1_next, r2_next, r1_reg, r2_reg;

    always_comb
    begin
        r1_next = f1_reg.vx;
        r2_next = '0;
        if (!f1_reg.found)
        begin
            r1_next = dflt_reg;
            r2_next = (mode_reg == dati_pkg::MODE_VECTOR) ? dflt_reg : '0;
        end
        else
        begin
            case (mode_reg)
                dati_pkg::MODE_SCALAR:
                    r1_next = f1_reg.vx;
                dati_pkg::MODE_VECTOR:
                begin
                    r1_next = f1_reg.vx;
                    r2_next = f1_reg.vy;
                end
                dati_pkg::MODE_MAGNITUDE:
                    r1_next = !f1_reg.hasf ? f1_reg.vx
                                           : (f1_reg.uvd ? dflt_reg : f1_reg.smag);
                dati_pkg::MODE_DIRECTION:
                    r1_next = f1_reg.uvd ? dflt_reg : f1_reg.ang;
                default:
                    r1_next = f1_reg.vx;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_reg <= f1_next;
            r1_reg <= r1_next;
            r2_reg <= r2_next;
        end
    end

    assign result_valid  = vld_reg[LAT-1];
    assign first_result  = r1_reg;
    assign second_result = r2_reg;

    // checks
    `DATI_ASSERT_NEXT(a_accept_enters, clk, rst_n, item_valid && item_ready, vld_reg[0])
    `DATI_ASSERT_NEXT(a_frozen_on_stall, clk, rst_n, !item_ready, $stable(vld_reg))
    `DATI_ASSERT_NEXT(a_last_stage_lands, clk, rst_n, vld_reg[LAT-2] && item_ready, result_valid)
    `DATI_ASSERT_IMP(a_stall_from_output, clk, rst_n, !item_ready, result_valid && !result_ready)

endmodule

/* design/dati_sqrt.sv */
// Pipelined floor square root, 64-bit radicand, one root bit per stage.
// Depends on dati_pkg.
module dati_sqrt (
    input  logic                             clk,
    input  logic                             en,
    input  logic [dati_pkg::SQRT_IN_W-1:0]   radicand,
    output logic [dati_pkg::SQRT_OUT_W-1:0]  root
);

    localparam int STG = dati_pkg::SQRT_STAGES;
    localparam int RW  = dati_pkg::SQRT_REM_W;
    localparam int IW  = dati_pkg::SQRT_IN_W;
    localparam int OW  = dati_pkg::SQRT_OUT_W;

    logic [RW-1:0] rem_reg  [STG];
    logic [OW-1:0] root_reg [STG];
    logic [IW-1:0] rad_reg  [STG];

    for (genvar s = 0; s < STG; s++) begin : g_stage
        logic [RW-1:0] rem_in;
        logic [RW-1:0] trial_rem;
        logic [RW-1:0] trial;
        logic [RW-1:0] rem_next;
        logic [OW-1:0] root_in;
        logic [OW-1:0] root_next;
        logic [IW-1:0] rad_in;

        if (s == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = radicand;
        end
        else begin : g_rest
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign rad_in  = rad_reg[s-1];
        end

        // bring down two radicand bits, try (4*root + 1)
        always_comb
        begin
            trial_rem = {rem_in[RW-3:0], rad_in[IW-1-2*s -: 2]};
            trial     = {root_in, 2'b01};
            if (trial_rem >= trial)
            begin
                rem_next  = trial_rem - trial;
                root_next = {root_in[OW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial_rem;
                root_next = {root_in[OW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
                rad_reg[s]  <= rad_in;
            end
        end
    end

    assign root = root_reg[STG-1];

endmodule

/* design/dati_lane.sv */
// One interpolation lane: dry-aware weighted sum of three corners with
// renormalising divide (restoring, one quotient bit per stage). Depends on dati_pkg.
module dati_lane (
    input  logic                                   clk,
    input  logic                                   en,
    input  logic signed [dati_pkg::VAL_W-1:0]      dflt,
    input  logic [2:0][dati_pkg::VAL_W-1:0]        val,
    input  logic [2:0]                             wet,
    input  logic [2:0][dati_pkg::W_W-1:0]          wgt,
    output logic signed [dati_pkg::VAL_W-1:0]      result
);

    localparam int PW = dati_pkg::PROD_W;
    localparam int NW = dati_pkg::NUM_W;
    localparam int DW = dati_pkg::DIV_W;
    localparam int EW = dati_pkg::DEN_W;
    localparam logic signed [DW:0] SAT_HI = (DW+1)'(dati_pkg::VAL_MAX);
    localparam logic signed [DW:0] SAT_LO = -SAT_HI - 1;

    // stage 1: products, wet count, effective denominator
    logic signed [PW-1:0]  prod_next [3];
    logic signed [PW-1:0]  prod_reg  [3];
    logic [2:0]            wet1_reg;
    dati_pkg::lane_side_t  side1_next, side1_reg;
    logic [EW-1:0]         den_sum;
    logic [1:0]            wet_cnt;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_next[i] = $signed(val[i]) * $signed({1'b0, wgt[i]});
        end
        den_sum = (wet[0] ? EW'(wgt[0]) : '0) + (wet[1] ? EW'(wgt[1]) : '0)
                + (wet[2] ? EW'(wgt[2]) : '0);
        wet_cnt = 2'(wet[0]) + 2'(wet[1]) + 2'(wet[2]);
        side1_next.neg   = 1'b0;
        side1_next.den   = den_sum;
        side1_next.first = wet[0] ? $signed(val[0]) : (wet[1] ? $signed(val[1])
                                                              : $signed(val[2]));
        case (wet_cnt)
            2'd0:    side1_next.kind = dati_pkg::KIND_DFLT;
            2'd1:    side1_next.kind = dati_pkg::KIND_FIRST;
            2'd2:    side1_next.kind = (den_sum == '0) ? dati_pkg::KIND_DFLT
                                                       : dati_pkg::KIND_DIV;
            default:
            begin
                side1_next.kind = dati_pkg::KIND_DIV;
                side1_next.den  = EW'(dati_pkg::WEIGHT_ONE);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= prod_next[i];
            end
            wet1_reg  <= wet;
            side1_reg <= side1_next;
        end
    end

    // stage 2: numerator
    logic signed [NW-1:0] num_next, num_reg;
    dati_pkg::lane_side_t side2_reg;

    always_comb
    begin
        num_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (wet1_reg[i])
            begin
                num_next = num_next + NW'(prod_reg[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg   <= num_next;
            side2_reg <= side1_reg;
        end
    end

    // stage 3: magnitude plus half the divisor, for round half away from zero
    logic [NW-1:0]        abs_num;
    logic [DW-1:0]        dvd_next, dvd3_reg;
    dati_pkg::lane_side_t side3_next, side3_reg;

    always_comb
    begin
        abs_num        = num_reg[NW-1] ? (NW'(0) - num_reg) : num_reg;
        dvd_next       = abs_num[DW-1:0] + DW'(side2_reg.den >> 1);
        side3_next     = side2_reg;
        side3_next.neg = num_reg[NW-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dvd3_reg  <= dvd_next;
            side3_reg <= side3_next;
        end
    end

    // restoring divider
    logic [EW-1:0]        drem_reg  [DW];
    logic [DW-1:0]        dquo_reg  [DW];
    logic [DW-1:0]        ddvd_reg  [DW];
    dati_pkg::lane_side_t dside_reg [DW];

    for (genvar s = 0; s < DW; s++) begin : g_div
        logic [EW-1:0]        rem_in;
        logic [DW-1:0]        quo_in;
        logic [DW-1:0]        dvd_in;
        dati_pkg::lane_side_t side_in;
        logic [EW:0]          trial;
        logic [EW-1:0]        rem_next;
        logic [DW-1:0]        quo_next;

        if (s == 0) begin : g_first
            assign rem_in  = '0;
            assign quo_in  = '0;
            assign dvd_in  = dvd3_reg;
            assign side_in = side3_reg;
        end
        else begin : g_rest
            assign rem_in  = drem_reg[s-1];
            assign quo_in  = dquo_reg[s-1];
            assign dvd_in  = ddvd_reg[s-1];
            assign side_in = dside_reg[s-1];
        end

        always_comb
        begin
            trial    = {rem_in, dvd_in[DW-1-s]};
            quo_next = quo_in;
            if (trial >= {1'b0, side_in.den})
            begin
                rem_next          = EW'(trial - {1'b0, side_in.den});
                quo_next[DW-1-s]  = 1'b1;
            end
            else
            begin
                rem_next = trial[EW-1:0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                drem_reg[s]  <= rem_next;
                dquo_reg[s]  <= quo_next;
                ddvd_reg[s]  <= dvd_in;
                dside_reg[s] <= side_in;
            end
        end
    end

    // stage 4: sign, saturate, pick by kind
    dati_pkg::lane_side_t         side_last;
    logic signed [DW:0]           qs;
    logic signed [dati_pkg::VAL_W-1:0] sat_q, result_next, result_reg;

    always_comb
    begin
        side_last = dside_reg[DW-1];
        qs = side_last.neg ? -$signed({1'b0, dquo_reg[DW-1]})
                           : $signed({1'b0, dquo_reg[DW-1]});
        if (qs > SAT_HI)
        begin
            sat_q = dati_pkg::VAL_MAX;
        end
        else if (qs < SAT_LO)
        begin
            sat_q = -dati_pkg::VAL_MAX - 32'sd1;
        end
        else
        begin
            sat_q = qs[dati_pkg::VAL_W-1:0];
        end
        case (side_last.kind)
            dati_pkg::KIND_FIRST: result_next = side_last.first;
            dati_pkg::KIND_DIV:   result_next = sat_q;
            default:              result_next = dflt;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

/* design/dati_cordic.sv */
// Pipelined CORDIC atan2 in degrees, 16 fraction bits, one rotation per stage.
// Depends on dati_pkg.
module dati_cordic #(
    parameter int STEPS = dati_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [dati_pkg::VAL_W-1:0]   x,
    input  logic signed [dati_pkg::VAL_W-1:0]   y,
    output logic signed [dati_pkg::ANG_W-1:0]   angle
);

    localparam int CW = dati_pkg::CORDIC_W;
    localparam int AW = dati_pkg::ANG_W;

    logic signed [CW-1:0] cx_reg [STEPS+1];
    logic signed [CW-1:0] cy_reg [STEPS+1];
    logic signed [AW-1:0] ca_reg [STEPS+1];
    logic                 cz_reg [STEPS+1];

    // pre-rotation into the right half plane
    logic signed [CW-1:0] xe, ye;
    always_comb
    begin
        xe = {{(CW-dati_pkg::VAL_W){x[dati_pkg::VAL_W-1]}}, x};
        ye = {{(CW-dati_pkg::VAL_W){y[dati_pkg::VAL_W-1]}}, y};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cz_reg[0] <= (x == '0) && (y == '0);
            if (x < 0)
            begin
                cx_reg[0] <= -xe;
                cy_reg[0] <= -ye;
                ca_reg[0] <= (y >= 0) ? dati_pkg::ANG_180 : dati_pkg::ANG_M180;
            end
            else
            begin
                cx_reg[0] <= xe;
                cy_reg[0] <= ye;
                ca_reg[0] <= '0;
            end
        end
    end

    // rotation steps
    for (genvar i = 0; i < STEPS; i++) begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cz_reg[i+1] <= cz_reg[i];
                if (cy_reg[i] > 0)
                begin
                    cx_reg[i+1] <= cx_reg[i] + (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] - (cx_reg[i] >>> i);
                    ca_reg[i+1] <= ca_reg[i] + dati_pkg::atan_entry(i);
                end
                else
                begin
                    cx_reg[i+1] <= cx_reg[i] - (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] + (cx_reg[i] >>> i);
                    ca_reg[i+1] <= ca_reg[i] - dati_pkg::atan_entry(i);
                end
            end
        end
    end

    assign angle = cz_reg[STEPS] ? '0 : ca_reg[STEPS];

endmodule
